// File: rtl/bcpe_pkg.sv
// Shared constants and types for the Bezier curve point evaluator.
`default_nettype none

package bcpe_pkg;

    localparam int COORD_W = 32;
    localparam int POINT_COUNT_W = 5;
    localparam int POINT_INDEX_W = 4;

    localparam int MAX_POINTS_DEF = 16;
    localparam int TIME_FRAC_BITS_DEF = 16;

    // Least number of cycles between the starts of two levels, set by the read-to-write
    // depth of the interpolation pipeline.
    localparam int LEVEL_GAP = 5;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] ADDR_POINT_COUNT = 3'd0;
    localparam logic REG_SEL_POINT_COUNT = 1'b0;
    localparam logic [POINT_COUNT_W-1:0] POINT_COUNT_RESET = 5'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam int LANES = 3;
    localparam int LANE_X = 2;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 0;

    typedef logic [LANES-1:0][COORD_W-1:0] point_t;

endpackage

`default_nettype wire

// File: rtl/bezier_curve_point_eval.sv
// Top level of the Bezier curve point evaluator (de Casteljau scheme).
//
//  Channel   Direction  Handshake                Payload
//  in        input      in_valid / in_ready      opcode, point_index, in_x/y/z, curve_time
//  out       output     out_valid / out_ready    out_x, out_y, out_z
//  apb       slave      psel, penable, pready    paddr, pwdata, prdata
//
// During an evaluation over n points the control memory (first level) or the work
// memory (later levels) is read one entry per cycle, and a level of three or four
// points waits for the three-stage interpolation pipeline to write back. Reset
// clears the control state only; a finished result waits in a holding register
// and then in the output register, so the next transaction can be taken while
// the output is stalled, once the holding register has emptied.
`default_nettype none

module bezier_curve_point_eval
    import bcpe_pkg::*;
#(
    parameter int MAX_POINTS     = MAX_POINTS_DEF,
    parameter int TIME_FRAC_BITS = TIME_FRAC_BITS_DEF
)(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic                        opcode,
    input  wire logic [POINT_INDEX_W-1:0]    point_index,
    input  wire logic signed [COORD_W-1:0]   in_x,
    input  wire logic signed [COORD_W-1:0]   in_y,
    input  wire logic signed [COORD_W-1:0]   in_z,
    input  wire logic [TIME_FRAC_BITS:0]     curve_time,

    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic signed [COORD_W-1:0]        out_x,
    output logic signed [COORD_W-1:0]        out_y,
    output logic signed [COORD_W-1:0]        out_z,

    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [PADDR_W-1:0]          paddr,
    input  wire logic [PDATA_W-1:0]          pwdata,
    output logic [PDATA_W-1:0]               prdata,
    output logic                             pready
);

    localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int LVL_W  = $clog2(MAX_POINTS + 1);
    localparam int CNT_W  = $clog2((MAX_POINTS > LEVEL_GAP) ? MAX_POINTS : LEVEL_GAP);
    localparam int TIME_W = TIME_FRAC_BITS + 1;
    localparam int TMUL_W = TIME_W + 1;
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + TMUL_W;
    localparam logic [TIME_W-1:0] TIME_ONE = TIME_W'(1) << TIME_FRAC_BITS;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // Configuration register
    logic [POINT_COUNT_W-1:0] pc_reg;
    logic                     cfg_we;

    // Sequencer
    logic [1:0]        state_reg, state_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              first_lvl_reg, first_lvl_next;
    logic [TIME_W-1:0] t_reg;
    logic [TIME_W-1:0] t_sat;
    logic [LVL_W-1:0]  n_eff;
    logic              in_acc, eval_acc, ctrl_we, rd_en, end_hit, done_hit;
    logic [IDX_W-1:0]  rd_addr;

    // Memories
    point_t ctrl_mem [MAX_POINTS];
    point_t work_mem [MAX_POINTS];
    point_t ctrl_rd_reg, work_rd_reg;

    // Stage 1: read data returned
    logic             p1_valid_reg, p1_first_reg, p1_last_reg, p1_single_reg, p1_ctrl_reg;
    logic [IDX_W-1:0] p1_addr_reg;
    point_t           b_pt;
    point_t           a_reg;

    // Stage 2: differences
    logic                     p2_valid_reg, p2_last_reg;
    logic [IDX_W-1:0]         p2_addr_reg;
    logic signed [DIFF_W-1:0] diff_reg [LANES];
    point_t                   base2_reg;

    // Stage 3: products and write back
    logic                     p3_valid_reg, p3_last_reg;
    logic [IDX_W-1:0]         p3_addr_reg;
    logic signed [PROD_W-1:0] prod_reg [LANES];
    point_t                   base3_reg;
    point_t                   sum_pt;
    logic signed [TMUL_W-1:0] t_mul;

    // Result holding and output registers
    logic   res_valid_reg;
    point_t res_pt_reg;
    logic   out_valid_reg;
    point_t out_pt_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == REG_SEL_POINT_COUNT);
    assign prdata = (paddr == ADDR_POINT_COUNT) ? PDATA_W'(pc_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= POINT_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            pc_reg <= pwdata[POINT_COUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Input handshake and sequencer
    // ------------------------------------------------------------------
    assign in_ready = (state_reg == ST_IDLE) && !res_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign eval_acc = in_acc && (opcode == OP_EVAL);
    assign ctrl_we  = in_acc && (opcode == OP_LOAD) && (32'(point_index) < MAX_POINTS);

    always_comb
    begin
        if (pc_reg == '0)
        begin
            n_eff = LVL_W'(1);
        end
        else if (32'(pc_reg) > MAX_POINTS)
        begin
            n_eff = LVL_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = LVL_W'(pc_reg);
        end
    end

    assign t_sat = (curve_time > TIME_ONE) ? TIME_ONE : curve_time;

    assign rd_en   = (state_reg == ST_RUN) && (32'(cnt_reg) < 32'(lvl_reg));
    assign rd_addr = cnt_reg[IDX_W-1:0];

    // A level ends once all its points are read; longer than that only when
    // the next level would otherwise read an entry before it is written back.
    assign end_hit = (32'(cnt_reg) + 32'd1 >= 32'(lvl_reg))
                     && ((lvl_reg <= LVL_W'(2)) || (32'(cnt_reg) >= LEVEL_GAP - 1));

    assign done_hit = (p3_valid_reg && p3_last_reg) || (p1_valid_reg && p1_single_reg);

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        cnt_next       = cnt_reg;
        first_lvl_next = first_lvl_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (eval_acc)
                begin
                    state_next     = ST_RUN;
                    lvl_next       = n_eff;
                    cnt_next       = '0;
                    first_lvl_next = 1'b1;
                end
            end
            ST_RUN:
            begin
                if (end_hit)
                begin
                    cnt_next = '0;
                    if (lvl_reg <= LVL_W'(2))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        lvl_next       = lvl_reg - LVL_W'(1);
                        first_lvl_next = 1'b0;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (done_hit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lvl_reg       <= '0;
            cnt_reg       <= '0;
            first_lvl_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            cnt_reg       <= cnt_next;
            first_lvl_reg <= first_lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eval_acc)
        begin
            t_reg <= t_sat;
        end
    end

    // ------------------------------------------------------------------
    // Control point and work memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ctrl_we)
        begin
            ctrl_mem[IDX_W'(point_index)] <= {in_x, in_y, in_z};
        end
        if (rd_en && first_lvl_reg)
        begin
            ctrl_rd_reg <= ctrl_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (p3_valid_reg)
        begin
            work_mem[p3_addr_reg] <= sum_pt;
        end
        if (rd_en && !first_lvl_reg)
        begin
            work_rd_reg <= work_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Interpolation pipeline
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= rd_en;
            p2_valid_reg <= p1_valid_reg && !p1_first_reg && !p1_single_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    assign b_pt  = p1_ctrl_reg ? ctrl_rd_reg : work_rd_reg;
    assign t_mul = $signed({1'b0, t_reg});

    always_comb
    begin
        for (int k = 0; k < LANES; k++)
        begin
            sum_pt[k] = base3_reg[k] + prod_reg[k][TIME_FRAC_BITS+COORD_W-1:TIME_FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        p1_first_reg  <= (cnt_reg == '0);
        p1_last_reg   <= (lvl_reg == LVL_W'(2)) && (cnt_reg == CNT_W'(1));
        p1_single_reg <= (lvl_reg == LVL_W'(1));
        p1_ctrl_reg   <= first_lvl_reg;
        p1_addr_reg   <= rd_addr;

        // The previous point of the level is the left end of the next step.
        if (p1_valid_reg)
        begin
            a_reg <= b_pt;
        end

        p2_last_reg <= p1_last_reg;
        p2_addr_reg <= p1_addr_reg - IDX_W'(1);
        base2_reg   <= a_reg;
        for (int k = 0; k < LANES; k++)
        begin
            diff_reg[k] <= $signed({b_pt[k][COORD_W-1], b_pt[k]})
                           - $signed({a_reg[k][COORD_W-1], a_reg[k]});
        end

        p3_last_reg <= p2_last_reg;
        p3_addr_reg <= p2_addr_reg;
        base3_reg   <= base2_reg;
        for (int k = 0; k < LANES; k++)
        begin
            prod_reg[k] <= t_mul * diff_reg[k];
        end
    end

    // ------------------------------------------------------------------
    // Result holding register and output stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_valid_reg && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
                res_valid_reg <= 1'b0;
            end
            else
            begin
                if (out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (done_hit)
                begin
                    res_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (done_hit)
        begin
            res_pt_reg <= p1_single_reg ? b_pt : sum_pt;
        end
        if (res_valid_reg && (!out_valid_reg || out_ready))
        begin
            out_pt_reg <= res_pt_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_pt_reg[LANE_X];
    assign out_y     = out_pt_reg[LANE_Y];
    assign out_z     = out_pt_reg[LANE_Z];

endmodule

`default_nettype wire

// File: rtl/bcpe_checker.sv
// Port-level checks on the Bezier curve point evaluator, bound to the top level.
`default_nettype none

module bcpe_checker
    import bcpe_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      opcode,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic signed [COORD_W-1:0] out_x,
    input wire logic signed [COORD_W-1:0] out_y,
    input wire logic signed [COORD_W-1:0] out_z
);

    // A stalled result transaction keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
                                    && $stable(out_z))
        else $error("result changed while stalled");

    // A load never produces a result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_LOAD) && !out_valid |=> !out_valid)
        else $error("result appeared after a load");

    // An evaluation occupies the block, so no transaction follows at once.
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_EVAL) |=> !in_ready)
        else $error("input taken directly after an evaluation");

endmodule

bind bezier_curve_point_eval bcpe_checker u_bcpe_checker (.*);

`default_nettype wire

// File: sim/bezier_curve_point_eval_test.sv
// Self-checking testbench for the Bezier curve point evaluator.
`timescale 1ns / 1ps

module bezier_curve_point_eval_test
    import bcpe_pkg::*;
;

    localparam int TF = TIME_FRAC_BITS_DEF;
    localparam int NPTS = MAX_POINTS_DEF;
    localparam longint TIME_ONE = longint'(1) << TF;
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT = 4000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fffffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

    typedef struct {
        logic                       op;
        logic [POINT_INDEX_W-1:0]   idx;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
        logic [TF:0]                t;
    } curve_item_t;

    typedef struct {
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  z;
    } curve_point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic                       opcode = OP_LOAD;
    logic [POINT_INDEX_W-1:0]   point_index = '0;
    logic signed [COORD_W-1:0]  in_x = '0;
    logic signed [COORD_W-1:0]  in_y = '0;
    logic signed [COORD_W-1:0]  in_z = '0;
    logic [TF:0]                curve_time = '0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [COORD_W-1:0]  out_x;
    logic signed [COORD_W-1:0]  out_y;
    logic signed [COORD_W-1:0]  out_z;

    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    bezier_curve_point_eval i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .point_index (point_index),
        .in_x        (in_x),
        .in_y        (in_y),
        .in_z        (in_z),
        .curve_time  (curve_time),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #4 clk = ~clk;

    curve_item_t  pending_items[$];
    curve_point_t expected_points[$];
    int           fault_count = 0;

    // Local copy of the block's control points and point count.
    logic signed [COORD_W-1:0] model_pts[NPTS][LANES];
    logic [POINT_COUNT_W-1:0]  model_count = POINT_COUNT_RESET;

    function automatic logic signed [COORD_W-1:0] interp_coord(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input longint t
    );
        longint diff;
        longint prod;
        diff = longint'(b) - longint'(a);
        prod = t * diff;
        return COORD_W'(longint'(a) + (prod >>> TF));
    endfunction

    // Applies one accepted transaction to the local copy and queues the curve point
    // that an evaluation must return.
    function automatic void track_curve(input curve_item_t item);
        logic signed [COORD_W-1:0] work[NPTS][LANES];
        curve_point_t pt;
        int n;
        longint t;
        if (item.op == OP_LOAD)
        begin
            model_pts[item.idx][0] = item.x;
            model_pts[item.idx][1] = item.y;
            model_pts[item.idx][2] = item.z;
            return;
        end
        n = int'(model_count);
        if (n < 1) n = 1;
        if (n > NPTS) n = NPTS;
        t = longint'(item.t);
        if (t > TIME_ONE) t = TIME_ONE;
        work = model_pts;
        for (int level = n; level > 1; level--)
            for (int i = 0; i + 1 < level; i++)
                for (int k = 0; k < LANES; k++)
                    work[i][k] = interp_coord(work[i][k], work[i+1][k], t);
        pt.x = work[0][0];
        pt.y = work[0][1];
        pt.z = work[0][2];
        expected_points = {expected_points, pt};
    endfunction

    function automatic void queue_item(
        input logic op,
        input logic [POINT_INDEX_W-1:0] idx,
        input logic signed [COORD_W-1:0] x,
        input logic signed [COORD_W-1:0] y,
        input logic signed [COORD_W-1:0] z,
        input logic [TF:0] t
    );
        curve_item_t item;
        item.op = op;
        item.idx = idx;
        item.x = x;
        item.y = y;
        item.z = z;
        item.t = t;
        pending_items = {pending_items, item};
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return COORD_W'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            default: return COORD_W'($urandom);
        endcase
    endfunction

    function automatic logic [TF:0] pick_time();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return (TF+1)'(TIME_ONE);
            2: return (TF+1)'($urandom_range(32'(TIME_ONE + 1), 32'((TIME_ONE << 1) - 1)));
            3: return (TF+1)'($urandom_range(0, 15));
            default: return (TF+1)'($urandom_range(0, 32'(TIME_ONE)));
        endcase
    endfunction

    // Input driver: bursts of transactions separated by random gaps.
    logic in_taken = 1'b0;
    int   burst_left = 0;
    int   gap_left = 0;

    always @(negedge clk)
    begin
        curve_item_t item;
        if (rst_n && !(in_valid && !in_taken))
        begin
            if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_items.size() > 0)
            begin
                item = pending_items.pop_front();
                opcode <= item.op;
                point_index <= item.idx;
                in_x <= item.x;
                in_y <= item.y;
                in_z <= item.z;
                curve_time <= item.t;
                in_valid <= 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30)
                                                           : $urandom_range(0, 3);
                end
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall pattern: always ready, random, or a fixed duty cycle.
    int stall_mode = 0;
    int stall_span = 0;
    int stall_tick = 0;

    always @(negedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_span = $urandom_range(20, 300);
        end
        stall_span--;
        stall_tick++;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= (stall_tick % 6) >= 4;
        endcase
    end

    // Monitor: predicts on accepted inputs and checks accepted outputs.
    always @(posedge clk)
    begin
        curve_item_t  item;
        curve_point_t want;
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            item.op = opcode;
            item.idx = point_index;
            item.x = in_x;
            item.y = in_y;
            item.z = in_z;
            item.t = curve_time;
            track_curve(item);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $error("unexpected result transaction: x=%0d y=%0d z=%0d",
                       out_x, out_y, out_z);
                fault_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                if (out_x !== want.x)
                begin
                    $error("out_x: expected %0d, got %0d", want.x, out_x);
                    fault_count++;
                end
                if (out_y !== want.y)
                begin
                    $error("out_y: expected %0d, got %0d", want.y, out_y);
                    fault_count++;
                end
                if (out_z !== want.z)
                begin
                    $error("out_z: expected %0d, got %0d", want.z, out_z);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no transaction completes.
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // A load gives no result, so the block is given time to settle after the
    // last expected curve point.
    task automatic wait_idle();
        while (pending_items.size() != 0 || in_valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_point_count(input logic [POINT_COUNT_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_POINT_COUNT;
        pwdata <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        model_count = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(value))
        begin
            $error("prdata: expected %0d, got %0d", value, prdata);
            fault_count++;
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    int count_plan[14] = '{3, 16, 1, 5, 0, 2, 31, 8, 4, 12, 2, 6, 0, 0};

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A single point comes back unchanged, whatever the time.
        queue_item(OP_LOAD, '0, COORD_MAX, COORD_MIN, '0, '0);
        queue_item(OP_EVAL, '0, '0, '0, '0, '0);
        queue_item(OP_EVAL, '0, '0, '0, '0, (TF+1)'(TIME_ONE));
        queue_item(OP_EVAL, '0, '0, '0, '0, '1);
        for (int i = 1; i < NPTS; i++)
            queue_item(OP_LOAD, POINT_INDEX_W'(i), (i % 2) ? COORD_MIN : COORD_MAX,
                       (i % 2) ? -32'sd1 : 32'sh00010000, pick_coord(), '1);
        wait_idle();

        // Two points: one interpolation across the whole coordinate range.
        set_point_count(POINT_COUNT_W'(2));
        queue_item(OP_EVAL, '0, '0, '0, '0, (TF+1)'(TIME_ONE >> 1));
        queue_item(OP_EVAL, '0, '0, '0, '0, (TF+1)'(1));
        queue_item(OP_EVAL, '0, '0, '0, '0, (TF+1)'(TIME_ONE - 1));
        wait_idle();

        // A count of zero acts as one, a count above the store as the full store.
        set_point_count('0);
        queue_item(OP_EVAL, '0, '0, '0, '0, (TF+1)'(12345));
        wait_idle();
        set_point_count('1);
        queue_item(OP_EVAL, '0, '0, '0, '0, (TF+1)'(TIME_ONE));
        queue_item(OP_EVAL, '0, '0, '0, '0, (TF+1)'(40000));
        wait_idle();

        count_plan[12] = $urandom_range(0, 31);
        count_plan[13] = $urandom_range(0, 31);
        foreach (count_plan[p])
        begin
            set_point_count(POINT_COUNT_W'(count_plan[p]));
            for (int k = 0; k < 82; k++)
            begin
                if ($urandom_range(0, 99) < 35)
                    queue_item(OP_LOAD, POINT_INDEX_W'($urandom_range(0, NPTS - 1)),
                               pick_coord(), pick_coord(), pick_coord(), pick_time());
                else
                    queue_item(OP_EVAL, POINT_INDEX_W'($urandom), pick_coord(),
                               pick_coord(), pick_coord(), pick_time());
            end
            wait_idle();
        end

        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
